@@ rtl/sse_pkg.sv @@
`default_nettype none
// shared types and constants for the sparse set engine
// no dependencies; compiled before every other file of the block
package sse_pkg;

	localparam int UNIVERSE_DEF = 1024;
	localparam int CAPACITY_DEF = 1024;

	localparam int MODE_W  = 3;
	localparam int KEY_W   = 10;
	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam int ERR_W   = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_LOOKUP = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_READ   = 3'd4
	} mode_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK          = 3'd0,
		ERR_NOT_PRESENT = 3'd1,
		ERR_ALREADY     = 3'd2,
		ERR_FULL        = 3'd3,
		ERR_SLOT_RANGE  = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

@@ rtl/sse_in_if.sv @@
`default_nettype none
// input channel of the sparse set engine: valid/ready plus request word
// depends on sse_pkg for the field widths
interface sse_in_if;
	import sse_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output mode, output key, output slot, input ready);
	modport sink   (input valid, input mode, input key, input slot, output ready);
endinterface
`default_nettype wire

@@ rtl/sse_out_if.sv @@
`default_nettype none
// output channel of the sparse set engine: valid/ready plus result word
// depends on sse_pkg for the field widths
interface sse_out_if;
	import sse_pkg::*;

	logic               valid;
	logic               ready;
	logic               hit;
	logic [SLOT_W-1:0]  found_slot;
	logic [KEY_W-1:0]   member_key;
	logic [COUNT_W-1:0] member_count;
	logic [ERR_W-1:0]   error_code;

	modport source (output valid, output hit, output found_slot, output member_key,
		output member_count, output error_code, input ready);
	modport sink   (input valid, input hit, input found_slot, input member_key,
		input member_count, input error_code, output ready);
endinterface
`default_nettype wire

@@ rtl/sse_ram.sv @@
`default_nettype none
// single-port-write, single-port-read synchronous ram with registered read data
// standalone; no package needed
module sse_ram #(
	parameter int  DEPTH = 1024,
	parameter int  WIDTH = 10,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-first: a read at the write address returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/sparse_set_engine_unit.sv @@
`default_nettype none
// sparse set engine: key map and dense member array in two synchronous rams
// a request word passes the lookup and finish phases; its result is registered
// as it retires; only then is a new word taken, since the ram reads depend
// (key map, then dense array at the mapped slot); a stalled output holds the engine
// reset: arst_n clears the member count and control only; ram contents stay
// undefined until written, which the dense cross-check makes harmless
// depends on sse_pkg, sse_in_if, sse_out_if and sse_ram
module sparse_set_engine_unit #(
	parameter int UNIVERSE = sse_pkg::UNIVERSE_DEF,
	parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sse_in_if.sink   in_w,
	sse_out_if.source out_w
);
	import sse_pkg::*;

	// widths that follow from the set geometry
	localparam int KA_W  = $clog2(UNIVERSE);            // key map address
	localparam int POS_W = $clog2(CAPACITY);            // dense slot
	localparam int CNT_W = $clog2(CAPACITY + 1);        // member count
	localparam int KX_W  = (KA_W > KEY_W) ? KA_W : KEY_W;
	localparam int SX_W  = (POS_W > SLOT_W) ? POS_W : SLOT_W;

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   fin_go;
	logic   out_valid_q;

	// item held across the two phases
	mode_t             mode_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [KA_W-1:0]   k2s_ra_s1;
	logic [POS_W-1:0]  d_ra_s1;
	logic [POS_W-1:0]  p_s2;
	logic [KEY_W-1:0]  last_s2;

	logic [CNT_W-1:0] count_q, count_d, count_cur;

	// ram ports
	logic              k2s_we, k2s_re;
	logic [KA_W-1:0]   k2s_waddr, k2s_raddr;
	logic [POS_W-1:0]  k2s_wdata, k2s_rdata;
	logic              dns_we, dns_re;
	logic [POS_W-1:0]  dns_waddr, dns_raddr;
	logic [KEY_W-1:0]  dns_wdata, dns_rdata;

	// forwarding of the writes made at the edge a new word is taken
	logic              fwd_k_v_q, fwd_d_v_q;
	logic [KA_W-1:0]   fwd_k_a_q;
	logic [POS_W-1:0]  fwd_k_d_q;
	logic [POS_W-1:0]  fwd_d_a_q;
	logic [KEY_W-1:0]  fwd_d_d_q;
	logic [POS_W-1:0]  p_fw;
	logic [KEY_W-1:0]  d1_fw;

	// finishing phase results
	logic              in_univ, hit;
	logic [POS_W-1:0]  pos;
	logic [KEY_W-1:0]  member;
	err_t              err;
	logic [KX_W-1:0]   key_in_x, key_s1_x, last_x;
	logic [SX_W-1:0]   slot_in_x;
	logic [CNT_W-1:0]  last_idx;

	sse_ram #(.DEPTH(UNIVERSE), .WIDTH(POS_W)) u_key_map (
		.clk   (clk),
		.we    (k2s_we),
		.waddr (k2s_waddr),
		.wdata (k2s_wdata),
		.re    (k2s_re),
		.raddr (k2s_raddr),
		.rdata (k2s_rdata)
	);

	sse_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W)) u_dense (
		.clk   (clk),
		.we    (dns_we),
		.waddr (dns_waddr),
		.wdata (dns_wdata),
		.re    (dns_re),
		.raddr (dns_raddr),
		.rdata (dns_rdata)
	);

	// the finish step retires when the output register is free or drains now
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_w.ready);
	assign in_w.ready = (state_q == ST_IDLE) || fin_go;
	assign accept   = in_w.valid && in_w.ready;

	// state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = accept ? ST_LOOK : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count seen by a word taken this cycle: the retiring word's update first
	assign count_cur = fin_go ? count_d : count_q;
	assign last_idx  = count_cur - CNT_W'(1);
	assign key_in_x  = KX_W'(in_w.key);
	assign slot_in_x = SX_W'(in_w.slot);

	// forwarded map entry and first dense word in the lookup phase
	assign p_fw  = (fwd_k_v_q && (fwd_k_a_q == k2s_ra_s1)) ? fwd_k_d_q : k2s_rdata;
	assign d1_fw = (fwd_d_v_q && (fwd_d_a_q == d_ra_s1)) ? fwd_d_d_q : dns_rdata;

	// read addressing: the map at the key, the dense array either at the slot
	// (read member) or at the last member (for remove), then at the mapped slot
	always_comb begin
		k2s_re    = accept;
		k2s_raddr = key_in_x[KA_W-1:0];
		dns_re    = accept || (state_q == ST_LOOK);
		if (state_q == ST_LOOK) begin
			dns_raddr = p_fw;
		end else if (mode_t'(in_w.mode) == MODE_READ) begin
			dns_raddr = slot_in_x[POS_W-1:0];
		end else begin
			dns_raddr = last_idx[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode_t'(in_w.mode);
			key_s1    <= in_w.key;
			slot_s1   <= in_w.slot;
			k2s_ra_s1 <= k2s_raddr;
			d_ra_s1   <= dns_raddr;
		end
		if (state_q == ST_LOOK) begin
			p_s2    <= p_fw;
			last_s2 <= d1_fw;
		end
	end

	// finish: cross-check the map entry against the dense array, then update
	assign key_s1_x = KX_W'(key_s1);
	assign last_x   = KX_W'(last_s2);
	assign in_univ  = 32'(key_s1) < 32'(UNIVERSE);
	assign hit      = in_univ && (CNT_W'(p_s2) < count_q) && (dns_rdata == key_s1);
	assign pos      = hit ? p_s2 : '0;

	always_comb begin
		err       = ERR_OK;
		member    = '0;
		count_d   = count_q;
		k2s_we    = 1'b0;
		k2s_waddr = key_s1_x[KA_W-1:0];
		k2s_wdata = count_q[POS_W-1:0];
		dns_we    = 1'b0;
		dns_waddr = count_q[POS_W-1:0];
		dns_wdata = key_s1;
		case (mode_s1)
			MODE_ADD: begin
				if (hit) begin
					err = ERR_ALREADY;
				end else if (!in_univ) begin
					err = ERR_NOT_PRESENT;
				end else if (32'(count_q) >= 32'(CAPACITY)) begin
					err = ERR_FULL;
				end else begin
					k2s_we  = fin_go;
					dns_we  = fin_go;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (!hit) begin
					err = ERR_NOT_PRESENT;
				end else begin
					// last member fills the freed slot
					dns_we    = fin_go;
					dns_waddr = p_s2;
					dns_wdata = last_s2;
					k2s_we    = fin_go && (32'(last_s2) < 32'(UNIVERSE));
					k2s_waddr = last_x[KA_W-1:0];
					k2s_wdata = p_s2;
					count_d   = count_q - CNT_W'(1);
				end
			end
			MODE_LOOKUP: begin
				if (!hit) begin
					err = ERR_NOT_PRESENT;
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			MODE_READ: begin
				if ((32'(slot_s1) < 32'(count_q)) && (32'(slot_s1) < 32'(CAPACITY))) begin
					member = last_s2;
				end else begin
					err = ERR_SLOT_RANGE;
				end
			end
			default: begin
				err = ERR_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			fwd_k_v_q   <= 1'b0;
			fwd_d_v_q   <= 1'b0;
		end else begin
			if (fin_go) begin
				count_q <= count_d;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_w.ready) begin
				out_valid_q <= 1'b0;
			end
			fwd_k_v_q <= k2s_we;
			fwd_d_v_q <= dns_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_k_a_q <= k2s_waddr;
		fwd_k_d_q <= k2s_wdata;
		fwd_d_a_q <= dns_waddr;
		fwd_d_d_q <= dns_wdata;
	end

	// output register
	logic               hit_q;
	logic [SLOT_W-1:0]  found_slot_q;
	logic [KEY_W-1:0]   member_key_q;
	logic [COUNT_W-1:0] member_count_q;
	err_t               error_code_q;

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hit_q          <= hit;
			found_slot_q   <= SLOT_W'(pos);
			member_key_q   <= member;
			member_count_q <= COUNT_W'(count_d);
			error_code_q   <= err;
		end
	end

	assign out_w.valid        = out_valid_q;
	assign out_w.hit          = hit_q;
	assign out_w.found_slot   = found_slot_q;
	assign out_w.member_key   = member_key_q;
	assign out_w.member_count = member_count_q;
	assign out_w.error_code   = error_code_q;

endmodule
`default_nettype wire
